>>> hw/rtl/chenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chenc_pkg;

    // chunk length bits taken from the input field
    localparam int LENGTH_BITS = 32;
    localparam int LEN_W       = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

    // hex header always spans eight nibbles before zero suppression
    localparam int HEX_DIGITS = 8;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int IDX_W      = $clog2(HEX_DIGITS);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HEX_DIGITS - 1);

    // input item kinds
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // framing characters
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_DIGIT = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h61;

    // work the back end carries out for one accepted item
    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_BYTE_END = 2'd1,
        OP_ERROR    = 2'd2,
        OP_HEADER   = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [HEX_W-1:0] hex;
        logic [IDX_W-1:0] start;
        logic             zero;
    } cmd_t;

    // lowercase ascii hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] w;
        w = {4'h0, d};
        if (d < 4'd10)
            return 8'(CH_DIGIT + w);
        else
            return 8'(CH_ALPHA + w - 8'd10);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/chenc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module chenc_front import chenc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [31:0] chunk_length,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        chunked_mode,
    output logic             push_valid,
    input  wire logic        push_ready,
    output cmd_t             push_cmd
);

    logic [LEN_W-1:0] bytes_reg, bytes_next;
    logic             mode_reg, mode_next;
    logic [LEN_W-1:0] len;
    logic [HEX_W-1:0] hex_val;
    logic [IDX_W-1:0] start_idx;

    // a mode write blocks input, so no word is taken alongside it
    assign in_ready  = push_ready && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign len       = chunk_length[LEN_W-1:0];

    // zero-extend length to the full header width
    always_comb
    begin
        hex_val            = '0;
        hex_val[LEN_W-1:0] = len;
    end

    // first printed digit: most significant nonzero nibble, or the last one
    always_comb
    begin
        start_idx = IDX_LAST;
        for (int i = 0; i < HEX_DIGITS; i++)
        begin
            if (hex_val[i*4 +: 4] != 4'h0)
                start_idx = IDX_W'(HEX_DIGITS - 1 - i);
        end
    end

    // classify the word and update chunk state
    always_comb
    begin
        bytes_next     = bytes_reg;
        mode_next      = mode_reg;
        push_valid     = 1'b0;
        push_cmd.op    = OP_BYTE;
        push_cmd.data  = payload_byte;
        push_cmd.hex   = hex_val;
        push_cmd.start = start_idx;
        push_cmd.zero  = (len == '0);
        if (cfg_valid)
        begin
            mode_next  = chunked_mode;
            bytes_next = '0;
        end
        else if (in_valid && in_ready)
        begin
            if (!mode_reg)
            begin
                push_valid = (kind == KIND_BYTE);
            end
            else if (kind == KIND_BYTE)
            begin
                push_valid = 1'b1;
                if (bytes_reg == '0)
                begin
                    push_cmd.op   = OP_ERROR;
                    push_cmd.data = '0;
                end
                else
                begin
                    bytes_next  = bytes_reg - LEN_W'(1);
                    push_cmd.op = (bytes_reg == LEN_W'(1)) ? OP_BYTE_END : OP_BYTE;
                end
            end
            else
            begin
                push_valid = 1'b1;
                if (bytes_reg != '0)
                begin
                    push_cmd.op   = OP_ERROR;
                    push_cmd.data = '0;
                end
                else
                begin
                    push_cmd.op = OP_HEADER;
                    bytes_next  = len;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/chenc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module chenc_fifo import chenc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> hw/rtl/chenc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module chenc_back import chenc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  cmd_t       pop_cmd,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       error
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DATA   = 7'b0000010,
        S_DIGIT  = 7'b0000100,
        S_CR     = 7'b0001000,
        S_LF_MID = 7'b0010000,
        S_CR_END = 7'b0100000,
        S_LF_END = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_fire, done;

    assign out_valid = (state_reg != S_IDLE);
    assign out_fire  = out_valid && out_ready;
    assign done      = (state_reg == S_IDLE) || (out_fire && last);
    assign pop_ready = done;

    // current output word
    always_comb
    begin
        out_byte = '0;
        last     = 1'b0;
        error    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                out_byte = '0;
            end
            S_DATA:
            begin
                out_byte = cmd_reg.data;
                last     = (cmd_reg.op != OP_BYTE_END);
                error    = (cmd_reg.op == OP_ERROR);
            end
            S_DIGIT:
            begin
                out_byte = hex_digit(cmd_reg.hex[(IDX_LAST - idx_reg) * 4 +: 4]);
            end
            S_CR, S_CR_END:
            begin
                out_byte = CH_CR;
            end
            S_LF_MID:
            begin
                out_byte = CH_LF;
            end
            S_LF_END:
            begin
                out_byte = CH_LF;
                last     = 1'b1;
            end
            default:
            begin
                out_byte = '0;
            end
        endcase
    end

    // byte sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        if (done)
        begin
            if (pop_valid)
            begin
                cmd_next   = pop_cmd;
                idx_next   = pop_cmd.start;
                state_next = (pop_cmd.op == OP_HEADER) ? S_DIGIT : S_DATA;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
        else if (out_fire)
        begin
            unique case (state_reg)
                S_DATA:
                begin
                    state_next = S_CR;
                end
                S_DIGIT:
                begin
                    if (idx_reg == IDX_LAST)
                        state_next = S_CR;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
                S_CR:
                begin
                    state_next = (cmd_reg.op == OP_HEADER && cmd_reg.zero) ? S_LF_MID : S_LF_END;
                end
                S_LF_MID:
                begin
                    state_next = S_CR_END;
                end
                S_CR_END:
                begin
                    state_next = S_LF_END;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/http_chunked_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Chunked transfer encoder. Each input word is either a chunk begin carrying a
// length or one payload byte; the output is the framed byte stream, one byte per
// word, with last marking the final byte an input word caused. A payload byte
// gives one output byte (three for the final byte of a chunk, which adds CR LF).
// A begin gives 1 to 8 hex length digits and CR LF, or 0 CR LF CR LF for the zero
// length last chunk. The output sequencer gives one byte per cycle while out_ready
// is high and commands wait. The front end classifies words at one per cycle into
// a two-entry command queue while it has room, so input is taken while the output
// side is stalled until the queue fills. Writing chunked_mode (1 = chunked, 0 =
// pass-through) closes any open chunk; write it only while the block is idle.
// Out-of-sequence words give one error byte of zero.

module http_chunked_encoder_unit import chenc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [31:0] chunk_length,
    input  wire logic [7:0]  payload_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        chunked_mode
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    // classify words and track the open chunk
    chenc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .chunk_length (chunk_length),
        .payload_byte (payload_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .chunked_mode (chunked_mode),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    // command queue between the two sides
    chenc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // emit the framed bytes
    chenc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error)
    );

endmodule

`default_nettype wire

>>> hw/rtl/chenc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module chenc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last,
    input wire logic       error
);

    // an error word is a lone zero byte
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> out_byte == 8'h00 && last)
        else $error("error word not a lone zero byte");

    // an offered word carries known bits
    a_word_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_byte, last, error}))
        else $error("output word has unknown bits");

    // a stalled word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn while stalled");

    // a stalled word keeps its contents
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(last) && $stable(error))
        else $error("output word changed while stalled");

endmodule

bind http_chunked_encoder_unit chenc_checker u_chk (.*);

`default_nettype wire
